// ----- sv/gct_pkg.sv -----
// Package for the glyph reference-count table.
// Holds the status codes and the fixed field types shared by the top level.
// No dependencies.
package gct_pkg;

  localparam int GLYPH_BITS = 16;

  typedef logic [2:0]            status_t;
  typedef logic [GLYPH_BITS-1:0] glyph_t;
  typedef logic [5:0]            slot_out_t;
  typedef logic [15:0]           count_out_t;

  localparam status_t ST_HIT          = 3'd0;
  localparam status_t ST_INSERT       = 3'd1;
  localparam status_t ST_NO_OUTLINE   = 3'd2;
  localparam status_t ST_DECREMENT    = 3'd3;
  localparam status_t ST_RELEASE      = 3'd4;
  localparam status_t ST_UNTRACK_MISS = 3'd5;
  localparam status_t ST_FULL         = 3'd6;
  localparam status_t ST_SATURATED    = 3'd7;

  localparam logic OP_TRACK   = 1'b0;
  localparam logic OP_UNTRACK = 1'b1;

endpackage

// ----- sv/glyph_refcount_table_top.sv -----
// Glyph reference-count table: one beat in, one result beat out.
// After reset a clearing pass writes every entry invalid, with input stalled.
// Per beat the single-port table memory is scanned one entry a cycle (registered read) until
// a hit or the last entry; the result is registered once the output register is free, and then
// the next beat is taken. Results wait in an output register, so the input
// is taken again while a result is still stalled.
module glyph_refcount_table_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  gct_pkg::glyph_t        glyph_index,
  input  logic                   has_outline,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gct_pkg::status_t       status,
  output gct_pkg::slot_out_t     slot,
  output gct_pkg::count_out_t    use_count
);
  import gct_pkg::*;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int WORD_W = 1 + GLYPH_BITS + COUNT_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(TABLE_ENTRIES);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  // entry word: {valid, glyph, count}
  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] mem_q;

  logic [1:0]            state;
  logic [IDX_W-1:0]      clr_addr;
  logic [IDX_W:0]        scan_addr;
  logic                  q_valid;
  logic [IDX_W-1:0]      q_slot;

  logic                  op;
  glyph_t                glyph;
  logic                  outline;
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_slot;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_idx;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [WORD_W-1:0]     wr_data;

  logic                  q_entry_valid;
  glyph_t                q_glyph;
  logic [COUNT_BITS-1:0] q_count;
  logic                  q_match;

  logic                  load_out;
  logic                  upd_wr;
  logic [IDX_W-1:0]      upd_idx;
  logic [WORD_W-1:0]     upd_data;
  status_t               res_status;
  logic [IDX_W-1:0]      res_slot;
  logic                  res_has_slot;
  logic [COUNT_BITS-1:0] res_count;

  assign in_stall = (state != S_IDLE);
  assign rd_en    = (state == S_SCAN) && (scan_addr != SCAN_END);
  assign rd_idx   = scan_addr[IDX_W-1:0];

  assign q_entry_valid = mem_q[WORD_W-1];
  assign q_glyph       = mem_q[WORD_W-2 -: GLYPH_BITS];
  assign q_count       = mem_q[COUNT_BITS-1:0];
  assign q_match       = q_valid && q_entry_valid && (q_glyph == glyph);

  assign load_out = (state == S_UPDATE) && (!out_valid || !out_stall);

  // result and write-back for the captured lookup
  always_comb begin
    upd_wr       = 1'b0;
    upd_idx      = hit_slot;
    upd_data     = '0;
    res_status   = ST_UNTRACK_MISS;
    res_slot     = hit_slot;
    res_has_slot = 1'b0;
    res_count    = '0;
    if (op == OP_TRACK) begin
      if (hit_found) begin
        res_has_slot = 1'b1;
        if (&hit_count) begin
          res_status = ST_SATURATED;
          res_count  = hit_count;
        end else begin
          res_status = ST_HIT;
          res_count  = hit_count + COUNT_BITS'(1);
          upd_wr     = 1'b1;
          upd_data   = {1'b1, glyph, res_count};
        end
      end else if (!outline) begin
        res_status = ST_NO_OUTLINE;
      end else if (free_found) begin
        res_status   = ST_INSERT;
        res_slot     = free_slot;
        res_has_slot = 1'b1;
        res_count    = COUNT_BITS'(1);
        upd_wr       = 1'b1;
        upd_idx      = free_slot;
        upd_data     = {1'b1, glyph, COUNT_BITS'(1)};
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      if (hit_found) begin
        res_has_slot = 1'b1;
        upd_wr       = 1'b1;
        if (hit_count <= COUNT_BITS'(1)) begin
          res_status = ST_RELEASE;
          upd_data   = {1'b0, glyph, COUNT_BITS'(0)};
        end else begin
          res_status = ST_DECREMENT;
          res_count  = hit_count - COUNT_BITS'(1);
          upd_data   = {1'b1, glyph, res_count};
        end
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = load_out && upd_wr;
      wr_idx  = upd_idx;
      wr_data = upd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      scan_addr <= '0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q_valid <= rd_en;
      if (rd_en) begin
        scan_addr <= scan_addr + (IDX_W + 1)'(1);
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state     <= S_SCAN;
            scan_addr <= '0;
          end
        end
        S_SCAN: begin
          // glyphs are unique, so the first match ends the scan
          if (q_match || (q_valid && q_slot == LAST_IDX)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_slot <= rd_idx;
    if (state == S_IDLE && in_valid) begin
      op         <= opcode;
      glyph      <= glyph_index;
      outline    <= has_outline;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == S_SCAN && q_valid) begin
      if (q_match) begin
        hit_found <= 1'b1;
        hit_slot  <= q_slot;
        hit_count <= q_count;
      end
      if (!q_entry_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= q_slot;
      end
    end
    if (load_out) begin
      status    <= res_status;
      slot      <= res_has_slot ? slot_out_t'(res_slot) : '0;
      use_count <= count_out_t'(res_count);
    end
  end

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("table written during scan");

  a_insert_count_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_INSERT) |-> (use_count == 16'd1))
    else $error("insert did not report count one");

  a_no_slot_zero_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_RELEASE || status == ST_UNTRACK_MISS ||
                   status == ST_NO_OUTLINE || status == ST_FULL))
    |-> (use_count == 16'd0))
    else $error("nonzero count on a result without a live entry");

  a_update_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && $past(state) == S_SCAN) |-> $past(q_valid))
    else $error("scan ended without read data");
`endif

endmodule
